[src/route_table_binary_search_macros.svh]
// ----------------------------------------------------------------------------
// Route table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_BINARY_SEARCH_MACROS_SVH
`define ROUTE_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication.
`define RTBS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RTBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rtbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table package
// Beat types, table entry type, opcodes and default sizes.
// ----------------------------------------------------------------------------
package rtbs_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 1024;
	localparam int COUNT_W = 11;

	localparam logic OPC_WRITE  = 1'b0;
	localparam logic OPC_LOOKUP = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [9:0]  entry_index;
		logic [31:0] entry_prefix;
		logic [31:0] entry_mask;
		logic [31:0] entry_next_hop;
		logic [1:0]  entry_port;
		logic [31:0] dest_addr;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [9:0]  found_index;
		logic [31:0] found_next_hop;
		logic [1:0]  found_port;
	} rsp_t;

	typedef struct packed {
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [1:0]  port;
	} entry_t;

	typedef struct packed {
		logic   en;
		entry_t entry;
	} tbl_wr_t;

endpackage

[src/rtbs_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtbs_table #(
	parameter int TABLE_DEPTH = rtbs_pkg::DEFAULT_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic             clk,
	input  rtbs_pkg::tbl_wr_t wr,
	input  logic [AW-1:0]    wr_addr,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output rtbs_pkg::entry_t rd_entry
);

	rtbs_pkg::entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.entry;
		end
	end

	// Hold read data between reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_addr];
		end
	end

endmodule

[src/rtbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table search control
// Accepts beats, issues table writes and runs the binary search probes.
// ----------------------------------------------------------------------------
`include "route_table_binary_search_macros.svh"

module rtbs_ctrl #(
	parameter int TABLE_DEPTH = rtbs_pkg::DEFAULT_TABLE_DEPTH,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rtbs_pkg::req_t    req,
	input  logic [CW-1:0]     count,
	output rtbs_pkg::tbl_wr_t wr,
	output logic [AW-1:0]     wr_addr,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  rtbs_pkg::entry_t  rd_entry,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rtbs_pkg::rsp_t    rsp
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;

	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [1:0]     state_q, state_d;
	logic [31:0]    addr_q, addr_d;
	logic [CW-1:0]  lo_q, lo_d, hix_q, hix_d, mid_q, mid_d;
	logic [31:0]    key;
	logic           key_eq, key_gt;
	logic [CW-1:0]  lo_n, hix_n, mid_n, mid_0;
	logic [CW:0]    sum_n, sum_0;
	logic           accept, rsp_free, res_load;
	logic           in_search;
	rtbs_pkg::rsp_t res_d, rsp_q;
	logic           rsp_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign in_search = (state_q == ST_SEARCH);

	// Writes go straight to the table at the accepting edge.
	assign wr.en = accept && (req.opcode == rtbs_pkg::OPC_WRITE)
		&& (32'(req.entry_index) < 32'(TABLE_DEPTH));
	assign wr.entry.prefix  = req.entry_prefix;
	assign wr.entry.mask    = req.entry_mask;
	assign wr.entry.gateway = req.entry_next_hop;
	assign wr.entry.port    = req.entry_port;
	assign wr_addr          = AW'(req.entry_index);

	// Probe compare against the entry from the most recent table read.
	assign key    = addr_q & rd_entry.mask;
	assign key_eq = (key == rd_entry.prefix);
	assign key_gt = (key > rd_entry.prefix);
	assign lo_n   = key_gt ? lo_q : mid_q + CW'(1);
	assign hix_n  = key_gt ? mid_q : hix_q;
	assign sum_n  = {1'b0, lo_n} + {1'b0, hix_n} - (CW+1)'(1);
	assign mid_n  = sum_n[CW:1];
	assign sum_0  = {1'b0, count} - (CW+1)'(1);
	assign mid_0  = sum_0[CW:1];

	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		lo_d     = lo_q;
		hix_d    = hix_q;
		mid_d    = mid_q;
		rd_en    = 1'b0;
		rd_addr  = AW'(mid_q);
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.opcode == rtbs_pkg::OPC_LOOKUP)) begin
					addr_d = req.dest_addr;
					lo_d   = '0;
					hix_d  = count;
					if (count == '0) begin
						state_d = ST_EMPTY;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(mid_0);
						mid_d   = mid_0;
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (key_eq) begin
					// Hit: hold here until the output register frees up.
					if (rsp_free) begin
						res_load             = 1'b1;
						res_d.hit            = 1'b1;
						res_d.found_index    = 10'(mid_q);
						res_d.found_next_hop = rd_entry.gateway;
						res_d.found_port     = rd_entry.port;
						state_d              = ST_IDLE;
					end
				end else if (lo_n < hix_n) begin
					rd_en   = 1'b1;
					rd_addr = AW'(mid_n);
					mid_d   = mid_n;
					lo_d    = lo_n;
					hix_d   = hix_n;
				end else if (rsp_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (rsp_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		lo_q   <= lo_d;
		hix_q  <= hix_d;
		mid_q  <= mid_d;
		if (res_load) begin
			rsp_q <= res_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RTBS_ASSERT_NEXT(a_read_feeds_search, rd_en, in_search, "read issued outside search")
	`RTBS_ASSERT_IMPL(a_range_live, in_search, lo_q < hix_q && hix_q <= DEPTH_C, "bad search range")
	`RTBS_ASSERT_IMPL(a_load_when_free, res_load, rsp_free, "result overwrites pending beat")
	`RTBS_ASSERT_IMPL(a_probe_in_range, in_search, mid_q >= lo_q && mid_q < hix_q, "probe off range")

endmodule

[src/route_table_binary_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table binary search engine
// Stores route entries and answers destination lookups by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): a write beat stores one entry at
//   entry_index and returns nothing; a lookup beat searches slots 0 to
//   min(route_count, TABLE_DEPTH)-1, kept by software in descending prefix order.
//   rsp channel (rsp_valid/rsp_ready/rsp): one beat per lookup, with hit,
//   slot, next hop and port, all zero on a miss.
//   cfg_we/cfg_wdata: writes route_count; change it only while idle.
// Timing: writes are taken back to back, one per cycle, while no lookup runs.
//   A lookup reads the table once per probe, at most ceil(log2(N+1)) probes
//   for N = min(route_count, TABLE_DEPTH), and loads the result register at
//   its last probe; the next request is taken in the cycle after that.
// Reset: route_count clears to zero and no beat is pending; table contents
//   stay undefined until written, with no clearing pass.
// Stall: the result register holds a beat while rsp_ready is low; the next
//   request is still taken, and its search holds its final probe until the
//   result register frees up.
// ----------------------------------------------------------------------------
module route_table_binary_search #(
	parameter int TABLE_DEPTH = rtbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  rtbs_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output rtbs_pkg::rsp_t               rsp,
	input  logic                         cfg_we,
	input  logic [rtbs_pkg::COUNT_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	// Width that holds both the register and the table depth.
	localparam int WW = (CW > rtbs_pkg::COUNT_W) ? CW : rtbs_pkg::COUNT_W;

	logic [rtbs_pkg::COUNT_W-1:0] route_count_q;
	logic [WW-1:0]                count_ext;
	logic [CW-1:0]                count_sat;
	rtbs_pkg::tbl_wr_t            wr;
	logic [AW-1:0]                wr_addr;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	rtbs_pkg::entry_t             rd_entry;

	// Hold the route count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
		end else if (cfg_we) begin
			route_count_q <= cfg_wdata;
		end
	end

	// Clamp the search span to the table size.
	assign count_ext = WW'(route_count_q);
	assign count_sat = (count_ext > WW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_ext);

	rtbs_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	rtbs_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.count     (count_sat),
		.wr        (wr),
		.wr_addr   (wr_addr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table binary search testbench
// Loads mostly sorted route tables, sets route_count between phases and checks
// every lookup answer against an in-order prediction of the search.
// ----------------------------------------------------------------------------
module testbench;
	import rtbs_pkg::*;

	localparam int DEPTH     = DEFAULT_TABLE_DEPTH;
	localparam int ITEM_GOAL = 1250;
	localparam int SETTLE    = 16;

	// Prediction of the lookup engine: its own table, count and the answers
	// still owed by the block, oldest first.
	class lookup_tracker;
		entry_t               routes [DEPTH];
		bit                   present [DEPTH];
		logic [COUNT_W-1:0]   route_count = '0;
		rsp_t                 answers_due [$];
		int                   mismatches = 0;

		function void set_count(logic [COUNT_W-1:0] value);
			route_count = value;
		endfunction

		// Walk the probe path for addr. Return 0 when the path touches a slot
		// that was never written, so the caller can steer clear of it.
		function bit search(logic [31:0] addr, output rsp_t answer);
			int          lo;
			int          hi;
			int          mid;
			int          span;
			logic [31:0] key;
			bit          clean;
			clean  = 1'b1;
			answer = '0;
			span   = int'(route_count);
			if (span > DEPTH) span = DEPTH;
			lo = 0;
			hi = span - 1;
			while (lo <= hi && !answer.hit) begin
				mid = (lo + hi) / 2;
				if (!present[mid]) clean = 1'b0;
				key = addr & routes[mid].mask;
				if (key == routes[mid].prefix) begin
					answer.hit            = 1'b1;
					answer.found_index    = mid[9:0];
					answer.found_next_hop = routes[mid].gateway;
					answer.found_port     = routes[mid].port;
				end else if (key > routes[mid].prefix) begin
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
			return clean;
		endfunction

		function void take_request(req_t beat);
			rsp_t answer;
			if (beat.opcode == OPC_WRITE) begin
				routes[beat.entry_index].prefix  = beat.entry_prefix;
				routes[beat.entry_index].mask    = beat.entry_mask;
				routes[beat.entry_index].gateway = beat.entry_next_hop;
				routes[beat.entry_index].port    = beat.entry_port;
				present[beat.entry_index]        = 1'b1;
			end else begin
				void'(search(beat.dest_addr, answer));
				answers_due.push_back(answer);
			end
		endfunction

		task report(string msg);
			if (mismatches < 50) $display("mismatch: %s", msg);
			mismatches++;
		endtask

		task match_answer(rsp_t got);
			rsp_t want;
			if (answers_due.size() == 0) begin
				report($sformatf("result beat %h with no lookup outstanding", got));
				return;
			end
			want = answers_due.pop_front();
			if (got.hit !== want.hit)
				report($sformatf("hit %b, want %b", got.hit, want.hit));
			if (got.found_index !== want.found_index)
				report($sformatf("found_index %h, want %h", got.found_index,
					want.found_index));
			if (got.found_next_hop !== want.found_next_hop)
				report($sformatf("found_next_hop %h, want %h", got.found_next_hop,
					want.found_next_hop));
			if (got.found_port !== want.found_port)
				report($sformatf("found_port %h, want %h", got.found_port,
					want.found_port));
		endtask
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               cfg_we    = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;

	lookup_tracker book = new();

	// Routes of the current phase and the slots they were written to.
	entry_t plan [$];
	int     plan_slot [$];

	int n_items       = 0;
	int send_idle_pct = 10;
	int rsp_stall_pct = 65;

	route_table_binary_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Drop rsp_ready at random; the stall rate follows the current idling regime.
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Sample result beats at the rising edge, where the handshake counts.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) book.match_answer(rsp);
	end

	// Present one request beat. Called at a falling edge, returns at one.
	// Valid is left high so that back-to-back beats keep it up without a dip.
	task automatic send_beat(req_t beat);
		// Pick the idling regime: receiver lazy first, then sender lazy, then none.
		if (n_items >= 2 * ITEM_GOAL / 3) begin
			send_idle_pct = 0;
			rsp_stall_pct = 0;
		end else if (n_items >= ITEM_GOAL / 3) begin
			send_idle_pct = 65;
			rsp_stall_pct = 10;
		end
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req       <= beat;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		book.take_request(beat);
		n_items++;
		@(negedge clk);
	endtask

	// Write beats carry a random dest_addr so its bits toggle as well.
	task automatic send_route(int slot, entry_t route);
		req_t beat;
		beat.opcode         = OPC_WRITE;
		beat.entry_index    = slot[9:0];
		beat.entry_prefix   = route.prefix;
		beat.entry_mask     = route.mask;
		beat.entry_next_hop = route.gateway;
		beat.entry_port     = route.port;
		beat.dest_addr      = $urandom;
		send_beat(beat);
	endtask

	// Lookup beats carry random entry fields, which the block must ignore.
	task automatic send_lookup(logic [31:0] addr);
		req_t beat;
		beat.opcode         = OPC_LOOKUP;
		beat.entry_index    = 10'($urandom);
		beat.entry_prefix   = $urandom;
		beat.entry_mask     = $urandom;
		beat.entry_next_hop = $urandom;
		beat.entry_port     = 2'($urandom);
		beat.dest_addr      = addr;
		send_beat(beat);
	endtask

	// Change route_count only once the block is idle: drop valid, wait for
	// every owed answer, then let a search's worth of cycles go by.
	task automatic set_route_count(int value);
		req_valid <= 1'b0;
		while (book.answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[COUNT_W-1:0];
		@(posedge clk);
		book.set_count(value[COUNT_W-1:0]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly prefix routes; now and then a scattered mask or a prefix with
	// bits outside its mask, which can never match.
	function automatic entry_t make_route();
		entry_t route;
		int     len;
		len        = $urandom_range(32);
		route.mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
		if ($urandom_range(9) == 0) route.mask = $urandom;
		route.prefix = $urandom & route.mask;
		if ($urandom_range(19) == 0) route.prefix = $urandom;
		route.gateway = $urandom;
		route.port    = 2'($urandom_range(3));
		return route;
	endfunction

	// Aim mostly inside a planned route, sometimes one bit off, sometimes wild.
	function automatic logic [31:0] pick_addr();
		int          j;
		logic [31:0] addr;
		addr = $urandom;
		if (plan.size() != 0) begin
			j = $urandom_range(plan.size() - 1);
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: addr = plan[j].prefix | ($urandom & ~plan[j].mask);
				6, 7: addr = plan[j].prefix ^ (32'h1 << $urandom_range(31));
				8: addr = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
				default: addr = $urandom;
			endcase
		end
		return addr;
	endfunction

	// Large count: write only the slots a search can reach within a few
	// levels. Inner nodes hold /10 routes that fall with the slot number, so
	// the table is sorted where it is probed; the deepest level holds default
	// routes, which end every search before an unwritten slot.
	task automatic load_search_tree(int span);
		int     lo_q [$];
		int     hi_q [$];
		int     lvl_q [$];
		int     lo;
		int     hi;
		int     lvl;
		int     mid;
		int     levels;
		entry_t route;
		levels = $urandom_range(2, 6);
		lo_q.push_back(0);
		hi_q.push_back(span - 1);
		lvl_q.push_back(0);
		while (lo_q.size() != 0) begin
			lo  = lo_q.pop_front();
			hi  = hi_q.pop_front();
			lvl = lvl_q.pop_front();
			if (lo <= hi) begin
				mid           = (lo + hi) / 2;
				route.gateway = $urandom;
				route.port    = 2'($urandom_range(3));
				if (lvl == levels) begin
					route.prefix = 32'h0;
					route.mask   = 32'h0;
				end else begin
					route.prefix = (DEPTH - 1 - mid) << 22;
					route.mask   = 32'hFFC0_0000;
					lo_q.push_back(lo);
					hi_q.push_back(mid - 1);
					lvl_q.push_back(lvl + 1);
					lo_q.push_back(mid + 1);
					hi_q.push_back(hi);
					lvl_q.push_back(lvl + 1);
				end
				send_route(mid, route);
				plan.push_back(route);
				plan_slot.push_back(mid);
			end
		end
	endtask

	// One phase: load a table, set the count while idle, then run lookups
	// with the odd rewrite or stray write mixed in.
	task automatic run_phase();
		int          n;
		int          count;
		int          span;
		int          k;
		int          t;
		int          tries;
		int          order [$];
		entry_t      route;
		logic [31:0] addr;
		rsp_t        scratch;
		plan.delete();
		plan_slot.delete();
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: count = DEPTH;
				1: count = 2047;
				2: count = $urandom_range(DEPTH + 1, 2046);
				default: count = $urandom_range(97, DEPTH - 1);
			endcase
			span = (count > DEPTH) ? DEPTH : count;
			load_search_tree(span);
		end else begin
			n = ($urandom_range(3) == 0) ? $urandom_range(25, 96) : $urandom_range(0, 24);
			for (int i = 0; i < n; i++) begin
				plan.push_back(make_route());
				plan_slot.push_back(i);
				order.push_back(i);
			end
			// Sort descending by prefix, except for the odd unsorted table.
			if ($urandom_range(5) != 0) begin
				for (int i = 1; i < n; i++) begin
					route = plan[i];
					k = i - 1;
					while (k >= 0 && plan[k].prefix < route.prefix) begin
						plan[k + 1] = plan[k];
						k--;
					end
					plan[k + 1] = route;
				end
			end
			// Write the slots in shuffled order.
			for (int i = n - 1; i > 0; i--) begin
				k        = $urandom_range(i);
				t        = order[i];
				order[i] = order[k];
				order[k] = t;
			end
			foreach (order[i]) send_route(order[i], plan[order[i]]);
			case ($urandom_range(7))
				0: count = $urandom_range(0, n);
				1: count = n + $urandom_range(1, 3);
				default: count = n;
			endcase
		end
		set_route_count(count);
		repeat ($urandom_range(4, 2 * plan.size() + 8)) begin
			if ($urandom_range(9) == 0 && plan.size() != 0) begin
				// Rewrite a live entry with a fresh next hop and port.
				k             = $urandom_range(plan.size() - 1);
				route         = plan[k];
				route.gateway = $urandom;
				route.port    = 2'($urandom_range(3));
				plan[k]       = route;
				send_route(plan_slot[k], route);
			end else if ($urandom_range(19) == 0) begin
				// Stray write anywhere; later searches may well reach it.
				send_route($urandom_range(DEPTH - 1), make_route());
			end else begin
				// Skip any address whose search would read an unwritten slot.
				tries = 0;
				do begin
					addr = pick_addr();
					tries++;
				end while (!book.search(addr, scratch) && tries < 8);
				if (book.search(addr, scratch)) send_lookup(addr);
			end
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table: every lookup misses without reading the table.
		set_route_count(0);
		send_lookup(32'h0000_0000);
		send_lookup(32'hFFFF_FFFF);

		// Three sorted routes plus a default route at the last slot.
		send_route(0, entry_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3});
		send_route(1, entry_t'{32'h8000_0000, 32'hFF00_0000, 32'h1234_5678, 2'd2});
		send_route(2, entry_t'{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 2'd1});
		send_route(DEPTH - 1, entry_t'{32'h0, 32'h0, 32'hAAAA_AAAA, 2'd1});
		set_route_count(3);
		send_lookup(32'hFFFF_FFFF);   // left from the middle, hit slot 0
		send_lookup(32'h80AB_0000);   // hit at the first probe
		send_lookup(32'h0000_0000);   // right from the middle, hit slot 2
		send_lookup(32'h0000_0001);   // right, no match at slot 2: miss
		send_lookup(32'hFFFF_FFFE);   // left, no match at slot 0: miss

		// Break the order: the search still follows the probe rule.
		send_route(1, entry_t'{32'h0000_0005, 32'hFFFF_FFFF, 32'h5555_5555, 2'd0});
		send_lookup(32'hFFFF_FFFF);
		send_lookup(32'h0000_0005);

		// Count beyond the table saturates; the first probe lands mid-table.
		send_route(511, entry_t'{32'h0, 32'h0, 32'h0F0F_0F0F, 2'd2});
		set_route_count(2047);
		send_lookup($urandom);
		set_route_count(DEPTH);
		send_lookup($urandom);
		set_route_count(1);
		send_lookup(32'h8000_0000);

		while (n_items < ITEM_GOAL) run_phase();

		// Drain: no more beats, wait for owed answers, then a short tail.
		req_valid <= 1'b0;
		while (book.answers_due.size() != 0) @(posedge clk);
		repeat (2 * SETTLE) @(posedge clk);
		if (book.answers_due.size() != 0)
			book.report($sformatf("%0d answers never arrived", book.answers_due.size()));
		if (book.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin : watchdog
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/rtbs_pkg.sv
src/rtbs_table.sv
src/rtbs_ctrl.sv
src/route_table_binary_search.sv
tb/sv/testbench.sv
